/* hdl/bas_pkg.sv */
package bas_pkg;

  // Field widths of the pixel and result channels.
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 16;
  localparam int SHADE_W = 4;
  localparam int SCALE_W = PIX_W + SHADE_W;

  // Configuration port.
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int BS_REG_W   = 5;
  localparam int FW_REG_W   = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 1'b1;

  localparam logic [BS_REG_W-1:0] BS_RESET = 5'd8;
  localparam logic [FW_REG_W-1:0] FW_RESET = 11'd640;

  // Shade scaling: (PIX_MAX - avg) * SHADE_LEVELS / 2**PIX_W.
  localparam logic [PIX_W-1:0]   PIX_MAX      = 8'hFF;
  localparam logic [SCALE_W-1:0] SHADE_LEVELS = 12'd10;
  localparam logic [SHADE_W-1:0] SHADE_MAX    = 4'd9;

  // Queue between the accumulate front and the divide back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last_in_row;
  } tile_sum_t;

endpackage

/* hdl/bas_in_if.sv */
interface bas_in_if import bas_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             end_of_frame;

  modport source (output valid, pixel, end_of_frame, input ready);
  modport sink (input valid, pixel, end_of_frame, output ready);
endinterface

/* hdl/bas_out_if.sv */
interface bas_out_if import bas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SHADE_W-1:0] shade_index;
  logic               end_of_tile_row;

  modport source (output valid, shade_index, end_of_tile_row, input ready);
  modport sink (input valid, shade_index, end_of_tile_row, output ready);
endinterface

/* hdl/bas_ram.sv */
module bas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

/* hdl/bas_front.sv */
module bas_front import bas_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BLOCK = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bas_in_if.sink                             in_stream,
  input  logic [$clog2(MAX_BLOCK+1)-1:0]     bs_eff,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     fw_eff,
  input  logic [QCNT_W-1:0]                  q_count,
  output logic                               push,
  output tile_sum_t                          push_data
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int TCW = $clog2(MAX_WIDTH + 1);
  localparam int BW  = $clog2(MAX_BLOCK + 1);
  localparam int RW  = $clog2(MAX_BLOCK);
  localparam int XW  = TCW + BW + 1;

  // Clearing pass over the tile sum memory after reset.
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // Raster position counters.
  logic [AW-1:0]  pos_r, pos_nxt;
  logic [RW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [TCW-1:0] tcol_r, tcol_nxt;

  // Read-modify-write stage.
  logic             s1_valid_r;
  logic [AW-1:0]    s1_addr_r;
  logic [PIX_W-1:0] s1_pixel_r;
  logic             s1_first_r;
  logic             s1_corner_r;
  logic             s1_last_r;
  logic             s1_fwd_r;
  logic [SUM_W-1:0] fwd_sum_r;

  logic             accept;
  logic [XW-1:0]    tile_end;
  logic             in_tile;
  logic             last_tile;
  logic             first_px;
  logic             corner_px;
  logic [XW-1:0]    col_inc, row_inc, pos_inc;
  logic [SUM_W-1:0] rd_sum;
  logic [SUM_W-1:0] acc;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic [SUM_W-1:0] ram_rdata;

  assign in_stream.ready = !clr_busy_r &&
    ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_r) < (QCNT_W+1)'(QUEUE_DEPTH));
  assign accept = in_stream.valid && in_stream.ready;

  // A tile is full when its right edge stays inside the row.
  assign tile_end  = XW'(tcol_r) * XW'(bs_eff) + XW'(bs_eff);
  assign in_tile   = tile_end <= XW'(fw_eff);
  assign last_tile = (tile_end + XW'(bs_eff)) > XW'(fw_eff);
  assign first_px  = (row_r == '0) && (col_r == '0);
  assign corner_px = (XW'(row_r) + XW'(1) == XW'(bs_eff)) &&
                     (XW'(col_r) + XW'(1) == XW'(bs_eff));

  assign col_inc = XW'(col_r) + XW'(1);
  assign row_inc = XW'(row_r) + XW'(1);
  assign pos_inc = XW'(pos_r) + XW'(1);

  always_comb begin
    col_nxt  = RW'(col_inc);
    tcol_nxt = tcol_r;
    row_nxt  = row_r;
    pos_nxt  = AW'(pos_inc);
    if (col_inc >= XW'(bs_eff)) begin
      col_nxt  = '0;
      tcol_nxt = tcol_r + TCW'(1);
    end
    if (pos_inc >= XW'(fw_eff)) begin
      pos_nxt  = '0;
      col_nxt  = '0;
      tcol_nxt = '0;
      row_nxt  = (row_inc >= XW'(bs_eff)) ? '0 : RW'(row_inc);
    end
    if (in_stream.end_of_frame) begin
      pos_nxt  = '0;
      col_nxt  = '0;
      row_nxt  = '0;
      tcol_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      pos_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
      tcol_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_WIDTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (accept) begin
        pos_r  <= pos_nxt;
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        tcol_r <= tcol_nxt;
      end
      s1_valid_r <= accept && in_tile;
    end
  end

  // The previous sum is forwarded when the next pixel hits the entry being written.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r   <= tcol_r[AW-1:0];
      s1_pixel_r  <= in_stream.pixel;
      s1_first_r  <= first_px;
      s1_corner_r <= corner_px;
      s1_last_r   <= last_tile;
      s1_fwd_r    <= s1_valid_r && (s1_addr_r == tcol_r[AW-1:0]);
      fwd_sum_r   <= acc;
    end
  end

  assign rd_sum = s1_fwd_r ? fwd_sum_r : ram_rdata;
  assign acc    = s1_first_r ? SUM_W'(s1_pixel_r) : rd_sum + SUM_W'(s1_pixel_r);

  assign ram_we    = clr_busy_r || s1_valid_r;
  assign ram_waddr = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clr_busy_r ? '0 : acc;

  assign push                  = s1_valid_r && s1_corner_r;
  assign push_data.sum         = acc;
  assign push_data.last_in_row = s1_last_r;

  bas_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_tile_sums (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (tcol_r[AW-1:0]),
    .rdata_r (ram_rdata)
  );

`ifndef ASSERT_OFF
  a_no_update_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s1_valid_r)
    else $error("tile update collided with the clearing pass");
`endif

endmodule

/* hdl/bas_queue.sv */
module bas_queue import bas_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tile_sum_t         push_data,
  input  logic              pop,
  output tile_sum_t         head,
  output logic [QCNT_W-1:0] count
);

  tile_sum_t          entries_r [QUEUE_DEPTH];
  logic [QADDR_W-1:0] wr_ptr_r;
  logic [QADDR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QADDR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QADDR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = entries_r[rd_ptr_r];
  assign count = count_r;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != QCNT_W'(QUEUE_DEPTH)))
    else $error("tile queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("tile queue underflow");
`endif

endmodule

/* hdl/bas_back.sv */
module bas_back import bas_pkg::*; #(
  parameter int MAX_BLOCK = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(MAX_BLOCK+1)-1:0] bs_eff,
  input  logic [QCNT_W-1:0]              q_count,
  input  tile_sum_t                      head,
  output logic                           pop,
  bas_out_if.source                      out_stream
);

  localparam int BW  = $clog2(MAX_BLOCK + 1);
  localparam int DW  = 2 * BW;
  localparam int SCW = $clog2(SUM_W + 1);

  logic [DW-1:0]      div_sq_r;
  logic               busy_r;
  logic [SCW-1:0]     step_r;
  logic [SUM_W-1:0]   dvd_r;
  logic [SUM_W-1:0]   quo_r;
  logic [DW-1:0]      rem_r;
  logic [DW-1:0]      dsr_r;
  logic               last_r;
  logic               out_valid_r;
  logic [SHADE_W-1:0] shade_r;
  logic               eot_r;

  logic [DW:0]        trial;
  logic               ge;
  logic [DW:0]        rem_sub;
  logic [SUM_W-1:0]   quo_next;
  logic               final_step;
  logic               out_free;
  logic               advance;
  logic [PIX_W-1:0]   avg;
  logic [SCALE_W-1:0] scaled;

  // Restoring division, one quotient bit per cycle, MSB first; the last bit waits until the previous shade is taken.
  assign trial    = {rem_r, dvd_r[SUM_W-1]};
  assign ge       = trial >= {1'b0, dsr_r};
  assign rem_sub  = ge ? (trial - {1'b0, dsr_r}) : trial;
  assign quo_next = {quo_r[SUM_W-2:0], ge};

  assign final_step = (step_r == SCW'(SUM_W - 1));
  assign out_free   = !out_valid_r || out_stream.ready;
  assign advance    = busy_r && (!final_step || out_free);
  assign pop        = !busy_r && (q_count != '0);

  // Averages above the pixel range saturate before scaling.
  assign avg    = (|quo_next[SUM_W-1:PIX_W]) ? PIX_MAX : quo_next[PIX_W-1:0];
  assign scaled = SCALE_W'(PIX_MAX - avg) * SHADE_LEVELS;

  always_ff @(posedge clk) begin
    div_sq_r <= DW'(bs_eff) * DW'(bs_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (advance) begin
        step_r <= step_r + SCW'(1);
        if (final_step) begin
          busy_r <= 1'b0;
        end
      end
      if (advance && final_step) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dvd_r  <= head.sum;
      quo_r  <= '0;
      rem_r  <= '0;
      dsr_r  <= div_sq_r;
      last_r <= head.last_in_row;
    end else if (advance) begin
      dvd_r <= {dvd_r[SUM_W-2:0], 1'b0};
      quo_r <= quo_next;
      rem_r <= rem_sub[DW-1:0];
      if (final_step) begin
        shade_r <= scaled[SCALE_W-1:PIX_W];
        eot_r   <= last_r;
      end
    end
  end

  assign out_stream.valid           = out_valid_r;
  assign out_stream.shade_index     = shade_r;
  assign out_stream.end_of_tile_row = eot_r;

`ifndef ASSERT_OFF
  a_shade_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (shade_r <= SHADE_MAX))
    else $error("shade index out of range");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r < SCW'(SUM_W)))
    else $error("divide step counter overran");
`endif

endmodule

/* hdl/block_average_shade_quantizer_core.sv */
// Channel     Direction  Payload                              Handshake
// in_stream   sink       pixel[7:0], end_of_frame             valid/ready
// out_stream  source     shade_index[3:0], end_of_tile_row    valid/ready
// cfg_*       sink       cfg_index[0], cfg_data[10:0]         cfg_we, no back-pressure
//
// The front takes one pixel request per cycle while in_stream.ready is high: a tile-sum
// read, then add and write-back. Each completed tile holds the back for one load plus sixteen
// divider steps, longer while the previous shade waits on out_stream.ready; one-pixel tiles
// are therefore throttled by the divider once the four-entry queue has filled.
// in_stream.ready drops while the queued tiles plus a pixel in the add stage reach four.
// After a synchronous, active-low reset the front clears all MAX_WIDTH entries of the
// tile-sum memory and takes no pixels; configuration writes are taken meanwhile.
module block_average_shade_quantizer_core import bas_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_BLOCK = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bas_in_if.sink                in_stream,
  bas_out_if.source             out_stream,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TCW = $clog2(MAX_WIDTH + 1);
  localparam int BW  = $clog2(MAX_BLOCK + 1);

  // Configuration registers, as written.
  logic [BS_REG_W-1:0] bs_r;
  logic [FW_REG_W-1:0] fw_r;

  // Effective values after clamping to the supported range.
  logic [BW-1:0]  bs_eff;
  logic [TCW-1:0] fw_eff;

  tile_sum_t         push_data;
  tile_sum_t         head;
  logic              push;
  logic              pop;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r <= BS_RESET;
      fw_r <= FW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SIZE:  bs_r <= cfg_data[BS_REG_W-1:0];
        CFG_FRAME_WIDTH: fw_r <= cfg_data[FW_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A zero register acts as one; values beyond the maximum act as the maximum.
  always_comb begin
    if (bs_r == '0) begin
      bs_eff = BW'(1);
    end else if (32'(bs_r) > 32'(MAX_BLOCK)) begin
      bs_eff = BW'(MAX_BLOCK);
    end else begin
      bs_eff = BW'(bs_r);
    end
    if (fw_r == '0) begin
      fw_eff = TCW'(1);
    end else if (32'(fw_r) > 32'(MAX_WIDTH)) begin
      fw_eff = TCW'(MAX_WIDTH);
    end else begin
      fw_eff = TCW'(fw_r);
    end
  end

  // The front tracks raster position and accumulates per-column tile sums.
  bas_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .bs_eff    (bs_eff),
    .fw_eff    (fw_eff),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  // Completed tile sums wait here for the divider.
  bas_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  // The back divides by the tile area and maps the average to a shade level.
  bas_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .bs_eff     (bs_eff),
    .q_count    (q_count),
    .head       (head),
    .pop        (pop),
    .out_stream (out_stream)
  );

endmodule

/* test/tb_block_average_shade_quantizer_core.sv */
module tb_block_average_shade_quantizer_core;
  import bas_pkg::*;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_BLOCK = 16;

  // Once every outstanding shade has come out, the only work that can still be
  // in flight is a pixel in the accumulate front, which never makes
  // a result. This many quiet cycles cover it with a wide margin.
  localparam int SETTLE_CYCLES = 40;

  // Long receiver hold-off that lets the four-entry tile queue fill up.
  localparam int HOLD_CYCLES = 400;

  // Cycles without any accepted request before the run is declared hung. The
  // longest correct gap is the clearing pass after reset, followed by the
  // hold-off above plus a full queue of divides.
  localparam int WATCHDOG_CYCLES = 8000;

  // Number of pixels driven after the directed table.
  localparam int RANDOM_ITEMS = 700;

  typedef struct packed {
    logic [SHADE_W-1:0] shade_index;
    logic               end_of_tile_row;
  } shade_res_t;

  // The directed table mixes pixel requests with register writes.
  typedef enum logic [1:0] {
    ROW_PIXEL,
    ROW_BLOCK,
    ROW_WIDTH
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_DATA_W-1:0] value;
    logic                  end_of_frame;
    logic                  typed;
    logic [SHADE_W-1:0]    shade_index;
    logic                  end_of_tile_row;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bas_in_if  in_stream ();
  bas_out_if out_stream ();

  block_average_shade_quantizer_core #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_BLOCK(MAX_BLOCK)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .out_stream(out_stream),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block: registers, per-column tile sums and the raster
  // position counters, all advanced once per accepted pixel request.
  logic [BS_REG_W-1:0] blk_reg;
  logic [FW_REG_W-1:0] wid_reg;
  logic [SUM_W-1:0]    tile_acc [MAX_WIDTH];
  int unsigned         col_pos;
  int unsigned         col_in_tile;
  int unsigned         row_in_tile;
  int unsigned         tile_col;

  // Shades predicted but not yet seen on the result channel, oldest first.
  shade_res_t pending_shades [$];

  int unsigned fail_count;
  int unsigned pixels_sent;
  int unsigned idle_cycles;
  // Remaining requests in a back-to-back stretch, one per side.
  int unsigned src_quiet;
  int unsigned sink_quiet;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit          hold_results;

  // The first block checks the simple cases by hand. With a tile edge of one
  // pixel each pixel is its own tile, so the shade follows straight from the
  // pixel value. With a two-pixel edge and a five-pixel row, the left tile is
  // all white, the right one all black, and the fifth column is a cut-off tile.
  // A short third row then ends the frame early, so the bottom tiles never
  // complete. The last rows change the tile edge while a frame is open.
  plan_row_t directed_plan [27] = '{
    '{ROW_BLOCK, 11'd1,   1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_WIDTH, 11'd3,   1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd255, 1'b0, 1'b1, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd0,   1'b0, 1'b1, 4'd9, 1'b0},
    '{ROW_PIXEL, 11'd128, 1'b0, 1'b1, 4'd4, 1'b1},
    '{ROW_PIXEL, 11'd1,   1'b1, 1'b1, 4'd9, 1'b0},
    '{ROW_PIXEL, 11'd254, 1'b1, 1'b1, 4'd0, 1'b0},
    '{ROW_BLOCK, 11'd2,   1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_WIDTH, 11'd5,   1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd255, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd255, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd0,   1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd0,   1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd77,  1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd255, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd255, 1'b0, 1'b1, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd0,   1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd0,   1'b0, 1'b1, 4'd9, 1'b1},
    '{ROW_PIXEL, 11'd200, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd10,  1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd20,  1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd30,  1'b1, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd100, 1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_BLOCK, 11'd0,   1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd50,  1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd60,  1'b0, 1'b0, 4'd0, 1'b0},
    '{ROW_PIXEL, 11'd70,  1'b1, 1'b0, 4'd0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A register value of zero behaves as one, and values past the build-time
  // maximum are clamped to it.
  function automatic int unsigned eff_block();
    if (blk_reg == '0) return 1;
    if (blk_reg > MAX_BLOCK) return MAX_BLOCK;
    return blk_reg;
  endfunction

  function automatic int unsigned eff_width();
    if (wid_reg == '0) return 1;
    if (wid_reg > MAX_WIDTH) return MAX_WIDTH;
    return wid_reg;
  endfunction

  // Adds one pixel into its tile column and advances the raster counters.
  // Returns 1 with the shade when the pixel is the bottom-right corner of a
  // full tile. Columns past the last full tile are skipped entirely.
  function automatic bit accumulate_pixel(input logic [PIX_W-1:0] px, input logic eof,
                                          output shade_res_t res);
    int unsigned bs;
    int unsigned fw;
    int unsigned full_tiles;
    int unsigned acc;
    int unsigned avg;
    bit          hit;
    bs = eff_block();
    fw = eff_width();
    full_tiles = fw / bs;
    hit = 1'b0;
    res = '0;
    if (tile_col < full_tiles && tile_col < MAX_WIDTH) begin
      // The sum restarts on the first pixel of every tile.
      if (row_in_tile == 0 && col_in_tile == 0) acc = px;
      else acc = (tile_acc[tile_col] + px) & 32'hFFFF;
      tile_acc[tile_col] = acc[SUM_W-1:0];
      if (row_in_tile == bs - 1 && col_in_tile == bs - 1) begin
        avg = acc / (bs * bs);
        if (avg > PIX_MAX) avg = PIX_MAX;
        res.shade_index = SHADE_W'((32'(PIX_MAX) - avg) * 32'(SHADE_LEVELS) / (32'd1 << PIX_W));
        res.end_of_tile_row = (tile_col == full_tiles - 1);
        hit = 1'b1;
      end
    end
    // After a register change the counters keep their values and simply wrap
    // the next time they reach or pass the new limit.
    col_in_tile++;
    if (col_in_tile >= bs) begin
      col_in_tile = 0;
      tile_col++;
    end
    col_pos++;
    if (col_pos >= fw) begin
      col_pos = 0;
      col_in_tile = 0;
      tile_col = 0;
      row_in_tile++;
      if (row_in_tile >= bs) row_in_tile = 0;
    end
    if (eof) begin
      col_pos = 0;
      col_in_tile = 0;
      row_in_tile = 0;
      tile_col = 0;
    end
    return hit;
  endfunction

  // Cycles to wait before the next request, drawn at random, with occasional stretches
  // of back-to-back requests.
  function automatic int unsigned draw_wait(inout int unsigned quiet_run);
    if (quiet_run != 0) begin
      quiet_run--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) quiet_run = $urandom_range(10, 40);
    return $urandom_range(0, 8);
  endfunction

  // Offers one pixel request and returns at the edge where it is accepted.
  // The expected shade is queued right there, so it always precedes the
  // result it belongs to. A typed row supplies its own expected shade.
  task automatic push_pixel(input logic [PIX_W-1:0] px, input logic eof,
                            input logic typed, input shade_res_t typed_res);
    int unsigned gap;
    shade_res_t  res;
    bit          hit;
    gap = draw_wait(src_quiet);
    if (gap != 0) begin
      in_stream.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_stream.valid        <= 1'b1;
    in_stream.pixel        <= px;
    in_stream.end_of_frame <= eof;
    @(posedge clk);
    while (!in_stream.ready) @(posedge clk);
    hit = accumulate_pixel(px, eof, res);
    if (typed) pending_shades.insert(pending_shades.size(), typed_res);
    else if (hit) pending_shades.insert(pending_shades.size(), res);
    pixels_sent++;
  endtask

  // Stops offering pixels and waits until every predicted shade has been
  // received and the front has had time to retire pixels that make none.
  task automatic wait_drained();
    in_stream.valid <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes only ever happen with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BLOCK_SIZE) blk_reg = data[BS_REG_W-1:0];
    else wid_reg = data[FW_REG_W-1:0];
  endtask

  // One frame (or a cut piece of one) around a random gray level, so that
  // completed tiles land on every shade. A frame left open carries no end of
  // frame marker, and the next register write then happens mid-frame.
  task automatic send_frame(input int unsigned count, input bit close);
    int unsigned level;
    int unsigned spread;
    int          v;
    level = $urandom_range(0, 255);
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 8;
      2: spread = 40;
      default: spread = 255;
    endcase
    for (int unsigned k = 0; k < count; k++) begin
      if (spread == 255) begin
        v = $urandom_range(0, 255);
      end else begin
        v = int'(level) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      push_pixel(v[PIX_W-1:0], close && (k == count - 1), 1'b0, '0);
    end
  endtask

  // One register setting followed by about budget pixels. Most frames hold
  // whole tile rows, some carry an extra partial row at the bottom, and a few
  // are cut short at a random pixel.
  task automatic run_phase(input logic [BS_REG_W-1:0] bs_val, input logic [FW_REG_W-1:0] fw_val,
                           input int unsigned budget, input bit all_regs, input bit hold);
    int unsigned bs;
    int unsigned fw;
    int unsigned sent;
    int unsigned n;
    bit          close;
    if (all_regs || $urandom_range(0, 3) != 0) write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(bs_val));
    if (all_regs || $urandom_range(0, 3) != 0) write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(fw_val));
    if (hold) hold_results = 1'b1;
    bs = eff_block();
    fw = eff_width();
    sent = 0;
    while (sent < budget) begin
      n = fw * (bs * $urandom_range(1, 2) + ($urandom_range(0, 3) == 0));
      if (n > budget) n = (bs * fw <= budget) ? bs * fw : $urandom_range(1, budget);
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
      close = !(sent + n >= budget && $urandom_range(0, 3) == 0);
      send_frame(n, close);
      sent += n;
    end
  endtask

  initial begin : stimulus
    plan_row_t           row;
    shade_res_t          typed_res;
    logic [BS_REG_W-1:0] bs_pick;
    logic [FW_REG_W-1:0] fw_pick;
    int unsigned         base;
    rst_n                  <= 1'b0;
    in_stream.valid        <= 1'b0;
    in_stream.pixel        <= '0;
    in_stream.end_of_frame <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_index              <= CFG_BLOCK_SIZE;
    cfg_data               <= '0;
    blk_reg      = BS_RESET;
    wid_reg      = FW_RESET;
    col_pos      = 0;
    col_in_tile  = 0;
    row_in_tile  = 0;
    tile_col     = 0;
    fail_count   = 0;
    pixels_sent  = 0;
    src_quiet    = 0;
    hold_results = 1'b0;
    foreach (tile_acc[i]) tile_acc[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // The block clears its sum memory first and holds off pixel requests
    // meanwhile; the register writes of the first rows land during that pass.
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      case (row.kind)
        ROW_BLOCK: write_reg(CFG_BLOCK_SIZE, row.value);
        ROW_WIDTH: write_reg(CFG_FRAME_WIDTH, row.value);
        default: begin
          typed_res.shade_index     = row.shade_index;
          typed_res.end_of_tile_row = row.end_of_tile_row;
          push_pixel(row.value[PIX_W-1:0], row.end_of_frame, row.typed, typed_res);
        end
      endcase
    end
    base = pixels_sent;

    // One-pixel tiles give a shade per pixel; with the receiver held off the
    // tile queue fills and the input has to stall.
    run_phase(5'd1, FW_REG_W'($urandom_range(4, 12)), 80, 1'b1, 1'b1);
    // All-ones tile edge clamps to the largest tile: one shade per 256 pixels.
    run_phase(5'd31, 11'd16, 256, 1'b1, 1'b0);
    // Widest row, clamped from all ones; only partial rows fit here.
    run_phase(5'd16, 11'd2047, 60, 1'b1, 1'b0);
    // Zero in both registers: one-pixel rows of one-pixel tiles, so every
    // pixel is a tile that also ends its tile row.
    run_phase(5'd0, 11'd0, 40, 1'b1, 1'b0);

    while (pixels_sent - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        6: bs_pick = '0;
        7: bs_pick = BS_REG_W'($urandom_range(5, 8));
        8: bs_pick = BS_REG_W'($urandom_range(9, 16));
        9: bs_pick = BS_REG_W'($urandom_range(17, 31));
        default: bs_pick = BS_REG_W'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 9))
        0: fw_pick = '0;
        1: fw_pick = FW_REG_W'($urandom_range(1025, 2047));
        2: fw_pick = FW_REG_W'($urandom_range(1, 3));
        default: fw_pick = FW_REG_W'($urandom_range(4, 24));
      endcase
      run_phase(bs_pick, fw_pick, $urandom_range(40, 120), 1'b0, 1'b0);
    end

    // Any shade that shows up during the final quiet stretch is unexpected
    // and gets flagged by the checker.
    wait_drained();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result receiver: a random stall before each result request, plus one long
  // hold-off on request from the stimulus.
  initial begin : result_sink
    int unsigned stall;
    sink_quiet = 0;
    out_stream.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_results) begin
        out_stream.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      stall = draw_wait(sink_quiet);
      if (stall != 0) begin
        out_stream.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_stream.ready <= 1'b1;
      @(posedge clk);
      while (!out_stream.valid) @(posedge clk);
    end
  end

  // Every accepted result request is matched against the oldest prediction.
  always @(posedge clk) begin : shade_check
    shade_res_t want;
    if (rst_n && out_stream.valid && out_stream.ready) begin
      if (pending_shades.size() == 0) begin
        $error("unexpected result: shade_index %0d end_of_tile_row %0d",
               out_stream.shade_index, out_stream.end_of_tile_row);
        fail_count++;
      end else begin
        want = pending_shades.pop_front();
        if (out_stream.shade_index !== want.shade_index) begin
          $error("shade_index: expected %0d, got %0d", want.shade_index,
                 out_stream.shade_index);
          fail_count++;
        end
        if (out_stream.end_of_tile_row !== want.end_of_tile_row) begin
          $error("end_of_tile_row: expected %0d, got %0d", want.end_of_tile_row,
                 out_stream.end_of_tile_row);
          fail_count++;
        end
      end
    end
  end

  // Hang detection: any accepted request on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_stream.valid && in_stream.ready) || (out_stream.valid && out_stream.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
